[rtl/core/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants, register codes and helpers of the car-following block.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int ACCEL_FRAC_BITS = 12;
  localparam int RATIO_BITS      = 16;

  // v*dv << accel frac / (sq << (speed frac + 1)) folds into one left shift
  localparam int TERM_SHIFT = ACCEL_FRAC_BITS - SPEED_FRAC_BITS - 1;

  localparam logic [31:0] RATIO_ONE = 32'(1) << RATIO_BITS;
  localparam logic [31:0] RATIO_CAP = 32'h8000_0000;

  // restoring divider: one quotient bit per stage
  localparam int DIV_STAGES = 36;
  localparam int DIV_NUM_W  = 52;
  localparam int DIV_DEN_W  = 20;
  localparam int DIV_QUO_W  = DIV_STAGES;

  // integer square root of a 30 bit product: two bits per stage
  localparam int SQRT_W      = 30;
  localparam int SQRT_STAGES = SQRT_W / 2;

  localparam int POW_STAGES = 15;

  // stage indexes counted from the input register (stage 0)
  localparam int T_RATIO  = DIV_STAGES;                  // v/v0 ready
  localparam int T_POWER  = T_RATIO + POW_STAGES;        // (v/v0)^delta ready
  localparam int T_ROOT   = 1 + SQRT_STAGES;             // sqrt(a*b) ready
  localparam int T_TERM   = T_ROOT + DIV_STAGES;         // dynamic gap term ready
  localparam int T_SSTAR  = T_TERM + 1;                  // desired gap registered
  localparam int T_GRATIO = T_SSTAR + DIV_STAGES;        // s*/s ready
  localparam int T_SQUARE = T_GRATIO + 1;
  localparam int T_COEF   = T_SQUARE + 1;
  localparam int T_MAG    = T_COEF + 1;
  localparam int LATENCY  = T_MAG + 1;                   // output register

  typedef enum logic [2:0] {
    REG_DESIRED_SPEED  = 3'd0,
    REG_SPEED_EXPONENT = 3'd1,
    REG_TIME_HEADWAY   = 3'd2,
    REG_STANDSTILL_GAP = 3'd3,
    REG_ACCEL_LIMIT    = 3'd4,
    REG_DECEL_LIMIT    = 3'd5
  } cfg_reg_t;

  function automatic logic [31:0] sat_cap(input logic [47:0] x);
    logic [31:0] y;
    y = (x > 48'(RATIO_CAP)) ? RATIO_CAP : x[31:0];
    return y;
  endfunction

endpackage

[rtl/core/cfa_if.sv]
// ----------------------------------------------------------------------------
// cfa interfaces
// Valid/ready channels for queries, results and register writes.
// ----------------------------------------------------------------------------
interface cfa_query_if;
  logic        valid;
  logic        ready;
  logic [15:0] own_speed;
  logic        front_present;
  logic [15:0] front_speed;
  logic [19:0] front_gap;
  modport source (output valid, own_speed, front_present, front_speed, front_gap,
                  input ready);
  modport sink (input valid, own_speed, front_present, front_speed, front_gap,
                output ready);
endinterface

interface cfa_accel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_cmd;
  modport source (output valid, accel_cmd, input ready);
  modport sink (input valid, accel_cmd, output ready);
endinterface

interface cfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/car_following_acceleration.sv]
// ----------------------------------------------------------------------------
// car_following_acceleration
// Intelligent driver model acceleration in a fully pipelined fixed-point path.
// ----------------------------------------------------------------------------
// Usage:
//   query  : valid/ready channel with own speed, front presence, front speed
//            and front gap; one transaction per cycle when ready is high
//   accel  : valid/ready channel with the clamped acceleration, one
//            transaction per query, in query order
//   cfg    : register writes (index, data), always ready; write only while
//            no query is in flight
// Each result is presented from the output register; throughput is one query
// per cycle while the receiver takes results. The pipeline length is set by the
// square root stages followed by two chained bit-per-stage dividers (the
// dynamic gap term and s*/s); the v/v0 divider and the power chain run
// alongside them. All stages share one enable: when a result waits on a
// stalled receiver the whole pipe holds and query.ready drops, so nothing is
// lost or repeated.
// Reset clears the stage valid bits and loads the default registers.
// ----------------------------------------------------------------------------
module car_following_acceleration
  import cfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cfa_cfg_if.sink   cfg,
  cfa_query_if.sink query,
  cfa_accel_if.source accel
);

  logic [15:0] desired_speed;
  logic [3:0]  speed_exponent;
  logic [11:0] time_headway;
  logic [15:0] standstill_gap;
  logic [14:0] accel_limit;
  logic [14:0] decel_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      desired_speed  <= 16'd8960;
      speed_exponent <= 4'd4;
      time_headway   <= 12'd384;
      standstill_gap <= 16'd512;
      accel_limit    <= 15'd4096;
      decel_limit    <= 15'd8192;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DESIRED_SPEED:  desired_speed  <= cfg.data;
        REG_SPEED_EXPONENT: speed_exponent <= cfg.data[3:0];
        REG_TIME_HEADWAY:   time_headway   <= cfg.data[11:0];
        REG_STANDSTILL_GAP: standstill_gap <= cfg.data;
        REG_ACCEL_LIMIT:    accel_limit    <= cfg.data[14:0];
        REG_DECEL_LIMIT:    decel_limit    <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic vld [LATENCY+1];

  assign adv         = !vld[LATENCY] || accel.ready;
  assign query.ready = adv;
  assign accel.valid = vld[LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LATENCY; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= query.valid;
      for (int i = 1; i <= LATENCY; i++) vld[i] <= vld[i-1];
    end
  end

  // stage 0: input register
  logic [15:0] v0r, vf0r;
  logic [19:0] gap0r;
  logic        pres0r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v0r    <= query.own_speed;
      vf0r   <= query.front_speed;
      gap0r  <= query.front_gap;
      pres0r <= query.front_present;
    end
  end

  logic [15:0] dv;
  logic [31:0] vdv_c;
  logic [27:0] vt_c;
  logic [29:0] ab_c;
  logic        cap1_c;

  assign dv     = (v0r >= vf0r) ? v0r - vf0r : vf0r - v0r;
  assign vdv_c  = v0r * dv;
  assign vt_c   = v0r * time_headway;
  assign ab_c   = accel_limit * decel_limit;
  assign cap1_c = (desired_speed == 16'd0) ||
                  ({16'd0, v0r} >= {1'b0, desired_speed, 15'd0});

  logic [31:0] vdv_r;
  logic [19:0] vt8_r;
  logic [29:0] ab_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vdv_r <= vdv_c;
      vt8_r <= vt_c[27:SPEED_FRAC_BITS];
      ab_r  <= ab_c;
    end
  end

  // delay lines; entry i sits at stage (first stage + i)
  logic        cap1_d [T_RATIO];
  logic        pres_d [T_GRATIO];
  logic [19:0] gap_d  [T_SSTAR];
  logic [31:0] vdv_d  [T_ROOT-1];
  logic [19:0] vt_d   [T_TERM-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cap1_d[0] <= cap1_c;
      pres_d[0] <= pres0r;
      gap_d[0]  <= gap0r;
      vdv_d[0]  <= vdv_r;
      vt_d[0]   <= vt8_r;
      for (int i = 1; i < T_RATIO; i++)  cap1_d[i] <= cap1_d[i-1];
      for (int i = 1; i < T_GRATIO; i++) pres_d[i] <= pres_d[i-1];
      for (int i = 1; i < T_SSTAR; i++)  gap_d[i]  <= gap_d[i-1];
      for (int i = 1; i < T_ROOT-1; i++) vdv_d[i]  <= vdv_d[i-1];
      for (int i = 1; i < T_TERM-1; i++) vt_d[i]   <= vt_d[i-1];
    end
  end

  // free-road ratio v/v0
  logic [DIV_QUO_W-1:0] quo1;
  logic [31:0]          ratio;

  cfa_div u_div_speed (
    .clk (clk),
    .en  (adv),
    .num (DIV_NUM_W'({v0r, 16'd0})),
    .den (DIV_DEN_W'(desired_speed)),
    .quo (quo1)
  );

  assign ratio = cap1_d[T_RATIO-1] ? RATIO_CAP : quo1[31:0];

  // power chain, one multiply per stage
  logic [31:0] pw [POW_STAGES];
  logic [31:0] rr [POW_STAGES];

  for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
    logic [31:0] pin, rin;
    logic [63:0] prod;
    if (k == 0) begin : g_first
      assign pin = RATIO_ONE;
      assign rin = ratio;
    end else begin : g_next
      assign pin = pw[k-1];
      assign rin = rr[k-1];
    end
    assign prod = pin * rin;
    always_ff @(posedge clk) begin
      if (adv) begin
        rr[k] <= rin;
        pw[k] <= (4'(k) < speed_exponent) ? sat_cap(prod[63:RATIO_BITS]) : pin;
      end
    end
  end

  logic [31:0] p_d [T_SQUARE-T_POWER];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_d[0] <= pw[POW_STAGES-1];
      for (int i = 1; i < T_SQUARE - T_POWER; i++) p_d[i] <= p_d[i-1];
    end
  end

  // sqrt(a*b) and the dynamic gap term v*dv/(2*sqrt(a*b))
  logic [15:0] root, sq;

  cfa_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .x    (ab_r),
    .root (root)
  );

  assign sq = (root == 16'd0) ? 16'd1 : root;

  logic [DIV_QUO_W-1:0] quo2;

  cfa_div u_div_term (
    .clk (clk),
    .en  (adv),
    .num (DIV_NUM_W'({vdv_d[T_ROOT-2], TERM_SHIFT'(0)})),
    .den (DIV_DEN_W'(sq)),
    .quo (quo2)
  );

  logic [35:0] sstar;

  always_ff @(posedge clk) begin
    if (adv) begin
      sstar <= 36'(standstill_gap) + 36'(vt_d[T_TERM-2]) + quo2;
    end
  end

  // gap ratio s*/s
  logic [19:0] gap_s;
  logic        cap2_c;
  logic        cap2_d [DIV_STAGES];

  assign gap_s  = gap_d[T_SSTAR-1];
  assign cap2_c = (gap_s == 20'd0) || (sstar >= {1'b0, gap_s, 15'd0});

  always_ff @(posedge clk) begin
    if (adv) begin
      cap2_d[0] <= cap2_c;
      for (int i = 1; i < DIV_STAGES; i++) cap2_d[i] <= cap2_d[i-1];
    end
  end

  logic [DIV_QUO_W-1:0] quo3;

  cfa_div u_div_gap (
    .clk (clk),
    .en  (adv),
    .num ({sstar, 16'd0}),
    .den (gap_s),
    .quo (quo3)
  );

  logic [31:0] qr;
  logic [63:0] qsq;
  logic [31:0] q_r;

  assign qr  = cap2_d[DIV_STAGES-1] ? RATIO_CAP : quo3[31:0];
  assign qsq = qr * qr;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= pres_d[T_GRATIO-1] ? sat_cap(qsq[63:RATIO_BITS]) : 32'd0;
    end
  end

  // coefficient, scaling by a and clamping
  logic signed [33:0] coef_r;
  logic [32:0]        mag_c;
  logic [47:0]        scaled;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic signed [15:0] cmd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      coef_r <= 34'sd65536 - $signed({2'b00, p_d[T_SQUARE-T_POWER-1]})
                           - $signed({2'b00, q_r});
    end
  end

  assign mag_c  = coef_r[33] ? 33'(-coef_r) : 33'(coef_r);
  assign scaled = mag_c * accel_limit;

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r <= coef_r[33];
      mag_r <= scaled[47:RATIO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!neg_r) begin
        cmd_r <= (mag_r > 32'(accel_limit)) ? $signed({1'b0, accel_limit})
                                            : $signed(mag_r[15:0]);
      end else begin
        cmd_r <= (mag_r > 32'(decel_limit)) ? -$signed({1'b0, decel_limit})
                                            : -$signed(mag_r[15:0]);
      end
    end
  end

  assign accel.accel_cmd = cmd_r;

endmodule

[rtl/core/cfa_div.sv]
// ----------------------------------------------------------------------------
// cfa_div
// Pipelined restoring divider, one quotient bit per stage, shared enable.
// ----------------------------------------------------------------------------
module cfa_div
  import cfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_QUO_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] rem [DIV_STAGES];
  logic [DIV_DEN_W-1:0] dn  [DIV_STAGES];
  logic [DIV_QUO_W-1:0] qo  [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - i;
    logic [DIV_NUM_W-1:0] rin;
    logic [DIV_DEN_W-1:0] din;
    logic [DIV_QUO_W-1:0] qin;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[i-1];
      assign din = dn[i-1];
      assign qin = qo[i-1];
    end

    assign ge = (rin >> K) >= DIV_NUM_W'(din);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? rin - (DIV_NUM_W'(din) << K) : rin;
        dn[i]  <= din;
        qo[i]  <= {qin[DIV_QUO_W-2:0], ge};
      end
    end
  end

  assign quo = qo[DIV_STAGES-1];

endmodule

[rtl/core/cfa_isqrt.sv]
// ----------------------------------------------------------------------------
// cfa_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cfa_isqrt
  import cfa_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQRT_W-1:0] x,
  output logic [15:0]       root
);

  logic [SQRT_W-1:0] xs [SQRT_STAGES];
  logic [SQRT_W-1:0] rs [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * j);
    logic [SQRT_W-1:0] xin, rin;
    logic [SQRT_W:0]   trial;

    if (j == 0) begin : g_first
      assign xin = x;
      assign rin = '0;
    end else begin : g_next
      assign xin = xs[j-1];
      assign rin = rs[j-1];
    end

    assign trial = (SQRT_W+1)'(rin) + (SQRT_W+1)'(BIT);

    always_ff @(posedge clk) begin
      if (en) begin
        if ((SQRT_W+1)'(xin) >= trial) begin
          xs[j] <= xin - trial[SQRT_W-1:0];
          rs[j] <= (rin >> 1) + BIT;
        end else begin
          xs[j] <= xin;
          rs[j] <= rin >> 1;
        end
      end
    end
  end

  assign root = rs[SQRT_STAGES-1][15:0];

endmodule

[rtl/core/cfa_checker.sv]
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the car-following block, bound to the top level.
// ----------------------------------------------------------------------------
module cfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_cmd
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd))
    else $error("result dropped or changed while stalled");

  // magnitude limits are at most 15 bits, so the most negative code never shows
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_cmd != 16'h8000)
    else $error("result below the deceleration range");

  // a stalled receiver holds the whole pipe
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("query taken while the pipe is stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipe not empty after reset");

endmodule

bind car_following_acceleration cfa_checker u_cfa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (query.ready),
  .out_valid (accel.valid),
  .out_ready (accel.ready),
  .out_cmd   (accel.accel_cmd)
);
